@@ rtl/b64d_pkg.sv @@
package b64d_pkg;

  typedef enum logic [1:0] {
    KIND_DATA,
    KIND_SKIP,
    KIND_BAD,
    KIND_PAD
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BADCHAR = 2'd1,
    ST_MISPAD  = 2'd2,
    ST_OPEN    = 2'd3
  } status_t;

  // one classified character as it travels from front to back
  typedef struct packed {
    kind_t      kind;
    logic [5:0] sextet;
    logic       last;
  } item_t;

  localparam int QueueDepth = 2;

  function automatic item_t classify(input logic [15:0] code, input logic last);
    item_t      it;
    logic [6:0] c;
    c         = code[6:0];
    it.last   = last;
    it.kind   = KIND_BAD;
    it.sextet = 6'd0;
    if (code[15:7] != 9'd0) begin
      it.kind = KIND_BAD;
    end else if (c >= 7'h41 && c <= 7'h5A) begin
      it.kind   = KIND_DATA;
      it.sextet = 6'(c - 7'h41);
    end else if (c >= 7'h61 && c <= 7'h7A) begin
      it.kind   = KIND_DATA;
      it.sextet = 6'(c - 7'h47);
    end else if (c >= 7'h30 && c <= 7'h39) begin
      it.kind   = KIND_DATA;
      it.sextet = 6'(c + 7'h04);
    end else if (c == 7'h2B) begin
      it.kind   = KIND_DATA;
      it.sextet = 6'd62;
    end else if (c == 7'h2F) begin
      it.kind   = KIND_DATA;
      it.sextet = 6'd63;
    end else if (c == 7'h3D) begin
      it.kind = KIND_PAD;
    end else if (c == 7'h09 || c == 7'h0A || c == 7'h0D || c == 7'h20 || c == 7'h2D) begin
      it.kind = KIND_SKIP;
    end
    return it;
  endfunction

endpackage

@@ rtl/base64_stream_decoder.sv @@
// Streaming base64 decoder. Each request carries one UTF-16 character and
// gives exactly one result: a decoded byte when the character completes one,
// the message-end flag, and the sticky status of the message so far (0 ok,
// 1 bad character, 2 misplaced padding, 3 unfinished group at end). Whitespace
// and '-' are skipped, '=' in the third or fourth place ends decoding until
// the last character. The block takes one character per cycle while the
// queue has room; an accepted request waits in the two-entry queue behind
// the classifier, then is decoded into the output register of the decode
// stage, where its result sits until taken. A stalled result holds, the
// queue fills behind it and the input stalls once both queue entries are
// taken. A consumer must drop the bytes of any message whose final status
// is not zero.
module base64_stream_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_char_code,
  input  logic        in_last_char,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_data_byte,
  output logic        out_byte_valid,
  output logic        out_message_end,
  output logic [1:0]  out_status
);

  logic            q_full;
  logic            q_push;
  logic            q_pop;
  logic            q_nonempty;
  b64d_pkg::item_t push_item;
  b64d_pkg::item_t pop_item;

  b64d_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_char_code (in_char_code),
    .in_last_char (in_last_char),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (push_item)
  );

  b64d_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .nonempty  (q_nonempty),
    .pop_item  (pop_item)
  );

  b64d_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_nonempty      (q_nonempty),
    .q_item          (pop_item),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data_byte   (out_data_byte),
    .out_byte_valid  (out_byte_valid),
    .out_message_end (out_message_end),
    .out_status      (out_status)
  );

endmodule

@@ rtl/b64d_front.sv @@
module b64d_front (
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [15:0]      in_char_code,
  input  logic             in_last_char,
  input  logic             q_full,
  output logic             q_push,
  output b64d_pkg::item_t  q_item
);

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign q_item   = b64d_pkg::classify(in_char_code, in_last_char);

endmodule

@@ rtl/b64d_queue.sv @@
module b64d_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  b64d_pkg::item_t  push_item,
  output logic             full,
  input  logic             pop,
  output logic             nonempty,
  output b64d_pkg::item_t  pop_item
);

  localparam int PtrW = $clog2(b64d_pkg::QueueDepth);
  localparam int CntW = $clog2(b64d_pkg::QueueDepth + 1);

  b64d_pkg::item_t mem_r [b64d_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;

  assign full     = (count_r == CntW'(b64d_pkg::QueueDepth));
  assign nonempty = (count_r != '0);
  assign pop_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(b64d_pkg::QueueDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(b64d_pkg::QueueDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ rtl/b64d_back.sv @@
module b64d_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_nonempty,
  input  b64d_pkg::item_t  q_item,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_data_byte,
  output logic             out_byte_valid,
  output logic             out_message_end,
  output logic [1:0]       out_status
);

  logic [1:0] grp_r, grp_nxt;
  logic [5:0] prev_r, prev_nxt;
  logic       pad_r, pad_nxt;
  logic [1:0] err_r, err_nxt;

  logic       out_valid_r;
  logic [7:0] byte_r, byte_nxt;
  logic       bvalid_r, bvalid_nxt;
  logic       end_r;
  logic [1:0] status_r, status_nxt;

  logic       active;

  assign q_pop  = q_nonempty && (!out_valid_r || !out_stall);
  assign active = (err_r == b64d_pkg::ST_OK) && !pad_r;

  always_comb begin
    grp_nxt    = grp_r;
    prev_nxt   = prev_r;
    pad_nxt    = pad_r;
    err_nxt    = err_r;
    byte_nxt   = 8'd0;
    bvalid_nxt = 1'b0;
    if (active) begin
      case (q_item.kind)
        b64d_pkg::KIND_BAD: begin
          err_nxt = b64d_pkg::ST_BADCHAR;
        end
        b64d_pkg::KIND_SKIP: begin
        end
        b64d_pkg::KIND_PAD: begin
          if (grp_r < 2'd2) begin
            err_nxt = b64d_pkg::ST_MISPAD;
          end else begin
            pad_nxt = 1'b1;
            grp_nxt = 2'd0;
          end
        end
        b64d_pkg::KIND_DATA: begin
          prev_nxt = q_item.sextet;
          case (grp_r)
            2'd0: begin
              grp_nxt = 2'd1;
            end
            2'd1: begin
              byte_nxt   = {prev_r, q_item.sextet[5:4]};
              bvalid_nxt = 1'b1;
              grp_nxt    = 2'd2;
            end
            2'd2: begin
              byte_nxt   = {prev_r[3:0], q_item.sextet[5:2]};
              bvalid_nxt = 1'b1;
              grp_nxt    = 2'd3;
            end
            default: begin
              byte_nxt   = {prev_r[1:0], q_item.sextet};
              bvalid_nxt = 1'b1;
              grp_nxt    = 2'd0;
            end
          endcase
        end
        default: begin
        end
      endcase
    end
    status_nxt = err_nxt;
    if (q_item.last && err_nxt == b64d_pkg::ST_OK && grp_nxt != 2'd0) begin
      status_nxt = b64d_pkg::ST_OPEN;
    end
    // clear message state after the last character
    if (q_item.last) begin
      grp_nxt  = 2'd0;
      prev_nxt = 6'd0;
      pad_nxt  = 1'b0;
      err_nxt  = b64d_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_r       <= 2'd0;
      prev_r      <= 6'd0;
      pad_r       <= 1'b0;
      err_r       <= b64d_pkg::ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        grp_r       <= grp_nxt;
        prev_r      <= prev_nxt;
        pad_r       <= pad_nxt;
        err_r       <= err_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      byte_r   <= byte_nxt;
      bvalid_r <= bvalid_nxt;
      end_r    <= q_item.last;
      status_r <= status_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_data_byte   = byte_r;
  assign out_byte_valid  = bvalid_r;
  assign out_message_end = end_r;
  assign out_status      = status_r;

endmodule

@@ rtl/b64d_checker.sv @@
module b64d_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_data_byte,
  input logic        out_byte_valid,
  input logic        out_message_end,
  input logic [1:0]  out_status
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data_byte)
      && $stable(out_status) && $stable(out_message_end))
    else $error("result changed while stalled");

  a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_data_byte == 8'd0)
    else $error("data byte not zero without a decoded byte");

  a_open_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == b64d_pkg::ST_OPEN |-> out_message_end)
    else $error("unfinished-group status before message end");

  a_byte_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_valid |->
      out_status == b64d_pkg::ST_OK || out_status == b64d_pkg::ST_OPEN)
    else $error("byte decoded under an error status");

endmodule

bind base64_stream_decoder b64d_checker u_b64d_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_data_byte   (out_data_byte),
  .out_byte_valid  (out_byte_valid),
  .out_message_end (out_message_end),
  .out_status      (out_status)
);
